/* rtl/ppmsm_pkg.sv */
package ppmsm_pkg;

    // Slot store geometry
    localparam int SLOTS   = 10;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int CNT_W   = 4;
    localparam logic [CNT_W:0] SLOTS_EXT = (CNT_W + 1)'(SLOTS);

    // Slots read by a mix
    localparam logic [SLOT_AW-1:0] ADDR_A = SLOT_AW'(1);
    localparam logic [SLOT_AW-1:0] ADDR_B = SLOT_AW'(2);
    localparam logic [SLOT_AW-1:0] ADDR_C = SLOT_AW'(4);

    // Commands
    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_MIX     = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd2;

    localparam logic [15:0] SYNC_THR_RST  = 16'd2050;
    localparam logic [11:0] MIN_ANGLE_RST = 12'd1300;
    localparam logic [11:0] MAX_ANGLE_RST = 12'd2300;

    // Mixer arithmetic, signed with headroom over two 16-bit operands
    localparam int MIX_W = 19;
    localparam logic signed [MIX_W-1:0] BASE_OFS = 19'sd300;
    localparam logic signed [MIX_W-1:0] CENTRE   = 19'sd1000;
    localparam logic signed [MIX_W-1:0] TRIM     = 19'sd500;

    localparam logic [2:0] SERVO_LAST = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pulse_width;
    } t_in;

    typedef struct packed {
        logic [2:0]  servo_index;
        logic [11:0] angle_x20;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_RD_C,
        S_CALC,
        S_EMIT
    } t_state;

endpackage

/* rtl/ppm_capture_servo_mixer.sv */
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_data  (ppmsm_pkg::t_in)
// result    out        o_valid / i_ready  o_data  (ppmsm_pkg::t_out)
// config    in         i_cfg_we           i_cfg_idx, i_cfg_wdata
//
// Captures are accepted back to back.
// A mix blocks the input in S_RD_B, S_RD_C and S_CALC while slots 1, 2 and 4 are read
// through the single read port of the slot memory, then emits five results at one per
// cycle while the output is not stalled; the next mix is taken once the block is back
// in S_IDLE; captures are accepted during the emission.
// Reset is synchronous and clears control state and per-slot valid bits at once.
// A stalled result holds in the output register and emission waits behind it.
module ppm_capture_servo_mixer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  ppmsm_pkg::t_in                       i_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ppmsm_pkg::t_out                      o_data,
    input  logic                                 i_cfg_we,
    input  logic [ppmsm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [15:0]                          i_cfg_wdata
);

    // Configuration
    logic [15:0] r_sync_thr;
    logic [11:0] r_min_angle;
    logic [11:0] r_max_angle;

    // Frame tracking
    logic [ppmsm_pkg::CNT_W-1:0] r_slot_count;
    logic                        r_frame_active;

    // Slot memory
    logic [15:0]                  r_slot_mem [ppmsm_pkg::SLOTS];
    logic [ppmsm_pkg::SLOTS-1:0]  r_slot_vld;
    logic [15:0]                  r_rd_data;
    logic                         r_rd_vld;
    logic [ppmsm_pkg::SLOT_AW-1:0] rd_addr;
    logic [15:0]                  rd_eff;

    // Sequencer
    ppmsm_pkg::t_state r_state, n_state;
    logic [2:0]        r_emit_idx, n_emit_idx;
    logic [15:0]       r_a, n_a, r_b, n_b, r_c, n_c;
    logic              r_out_valid, n_out_valid;
    ppmsm_pkg::t_out   r_out, n_out;

    logic in_acc, mix_acc, cap_acc, out_free;

    // Capture path
    logic                        cap_sync, cap_active, wr_en;
    logic [ppmsm_pkg::CNT_W-1:0] cap_cnt;
    logic [ppmsm_pkg::CNT_W:0]   cap_next;

    // Mixer
    logic        [15:0]                 mix_d;
    logic signed [ppmsm_pkg::MIX_W-1:0] c_s, d_s, mix_v, lo_s, hi_s, clamp_v;

    assign o_ready = (r_state == ppmsm_pkg::S_IDLE) ||
                     (r_state == ppmsm_pkg::S_EMIT && i_data.cmd == ppmsm_pkg::CMD_CAPTURE);
    assign in_acc   = i_valid && o_ready;
    assign mix_acc  = in_acc && i_data.cmd == ppmsm_pkg::CMD_MIX;
    assign cap_acc  = in_acc && i_data.cmd == ppmsm_pkg::CMD_CAPTURE;
    assign out_free = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A sync pulse restarts the frame at slot 0
    assign cap_sync   = i_data.pulse_width > r_sync_thr;
    assign cap_active = cap_sync || r_frame_active;
    assign cap_cnt    = cap_sync ? '0 : r_slot_count;
    assign cap_next   = {1'b0, cap_cnt} + 1'b1;
    assign wr_en      = cap_acc && cap_active && ({1'b0, cap_cnt} < ppmsm_pkg::SLOTS_EXT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_thr  <= ppmsm_pkg::SYNC_THR_RST;
            r_min_angle <= ppmsm_pkg::MIN_ANGLE_RST;
            r_max_angle <= ppmsm_pkg::MAX_ANGLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppmsm_pkg::CFG_SYNC_THR:  r_sync_thr  <= i_cfg_wdata;
                ppmsm_pkg::CFG_MIN_ANGLE: r_min_angle <= i_cfg_wdata[11:0];
                ppmsm_pkg::CFG_MAX_ANGLE: r_max_angle <= i_cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count   <= ppmsm_pkg::CNT_W'(1);
            r_frame_active <= 1'b0;
            r_slot_vld     <= '0;
        end else begin
            if (cap_acc && cap_active) begin
                r_frame_active <= cap_next < ppmsm_pkg::SLOTS_EXT;
                r_slot_count   <= cap_next[ppmsm_pkg::CNT_W-1:0];
            end
            if (wr_en) begin
                r_slot_vld[cap_cnt[ppmsm_pkg::SLOT_AW-1:0]] <= 1'b1;
            end
        end
    end

    // Read returns old data on a same-cycle write to the same slot
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[cap_cnt[ppmsm_pkg::SLOT_AW-1:0]] <= i_data.pulse_width;
        end
        r_rd_data <= r_slot_mem[rd_addr];
        r_rd_vld  <= r_slot_vld[rd_addr];
    end

    // A slot never written reads as zero
    assign rd_eff = r_rd_vld ? r_rd_data : '0;

    // Mix: servo 0/1 = c + d - 1200, servo 2/3 = c - d + 1800, servo 4 = c + 300
    assign mix_d = (r_emit_idx == 3'd0 || r_emit_idx == 3'd2) ? r_b : r_a;
    assign c_s   = signed'({3'b000, r_c});
    assign d_s   = signed'({3'b000, mix_d});
    assign lo_s  = signed'({7'b0000000, r_min_angle});
    assign hi_s  = signed'({7'b0000000, r_max_angle});

    always_comb begin
        case (r_emit_idx)
            3'd0, 3'd1: mix_v = c_s + ppmsm_pkg::BASE_OFS + d_s
                                - ppmsm_pkg::CENTRE - ppmsm_pkg::TRIM;
            3'd2, 3'd3: mix_v = c_s + ppmsm_pkg::BASE_OFS - d_s
                                + ppmsm_pkg::CENTRE + ppmsm_pkg::TRIM;
            default:    mix_v = c_s + ppmsm_pkg::BASE_OFS;
        endcase
        clamp_v = mix_v;
        if (clamp_v <= lo_s) clamp_v = lo_s;
        // upper limit wins when the limits cross
        if (clamp_v >= hi_s) clamp_v = hi_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppmsm_pkg::S_IDLE;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_emit_idx  <= n_emit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_emit_idx  = r_emit_idx;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        rd_addr     = ppmsm_pkg::ADDR_A;
        case (r_state)
            ppmsm_pkg::S_IDLE: begin
                if (mix_acc) n_state = ppmsm_pkg::S_RD_B;
            end
            ppmsm_pkg::S_RD_B: begin
                n_a     = rd_eff;
                rd_addr = ppmsm_pkg::ADDR_B;
                n_state = ppmsm_pkg::S_RD_C;
            end
            ppmsm_pkg::S_RD_C: begin
                n_b     = rd_eff;
                rd_addr = ppmsm_pkg::ADDR_C;
                n_state = ppmsm_pkg::S_CALC;
            end
            ppmsm_pkg::S_CALC: begin
                n_c        = rd_eff;
                n_emit_idx = '0;
                n_state    = ppmsm_pkg::S_EMIT;
            end
            ppmsm_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.servo_index = r_emit_idx;
                    n_out.angle_x20   = clamp_v[11:0];
                    n_out.last        = r_emit_idx == ppmsm_pkg::SERVO_LAST;
                    if (r_emit_idx == ppmsm_pkg::SERVO_LAST) begin
                        n_state = ppmsm_pkg::S_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + 3'd1;
                    end
                end
            end
            default: n_state = ppmsm_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppmsm_pkg::S_RD_B || r_state == ppmsm_pkg::S_RD_C ||
         r_state == ppmsm_pkg::S_CALC) |-> !o_ready)
        else $error("input accepted while mix slots are being read");

    a_mix_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_acc |=> r_state == ppmsm_pkg::S_RD_B)
        else $error("mix transaction did not start the slot reads");

    a_last_is_servo4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last == (o_data.servo_index == ppmsm_pkg::SERVO_LAST)))
        else $error("last flag out of step with servo index");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_active |-> ({1'b0, r_slot_count} < ppmsm_pkg::SLOTS_EXT))
        else $error("slot counter beyond store while frame active");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ppmsm_pkg::*;

    localparam int LIMIT     = 200000;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 16;
    localparam int BASE_ADD  = 300;
    localparam int MID_PULSE = 1000;
    localparam int TRIM_OFS  = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_in         i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out        o_data;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    ppm_capture_servo_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Mirror of the decoder state and its registers
    logic [15:0] thr_q;
    logic [11:0] min_q;
    logic [11:0] max_q;
    logic [15:0] slots [SLOTS];
    logic [3:0]  slot_cnt;
    logic        in_frame;

    t_in  pulses_pending [$];
    t_out angles_due [$];
    t_out want;

    int send_idle = 0;
    int recv_stall = 0;
    int n_fail = 0;
    int cycle_no = 0;
    int hold_left = 0;
    logic hold_start = 1'b0;

    function automatic logic [11:0] clamp_angle(input int v);
        int lo;
        int hi;
        lo = int'(min_q);
        hi = int'(max_q);
        if (v <= lo) v = lo;
        // max test last, so an inverted window yields the upper limit
        if (v >= hi) v = hi;
        return 12'(v);
    endfunction

    task automatic decode_item(input t_in it);
        int a;
        int b;
        int c;
        int base;
        int nxt;
        int k;
        int v [5];
        t_out r;
        if (it.cmd == CMD_CAPTURE) begin
            if (it.pulse_width > thr_q) begin
                in_frame = 1'b1;
                slot_cnt = '0;
            end
            if (in_frame) begin
                nxt = int'(slot_cnt) + 1;
                if (int'(slot_cnt) < SLOTS) slots[slot_cnt] = it.pulse_width;
                if (nxt >= SLOTS) in_frame = 1'b0;
                slot_cnt = 4'(nxt);
            end
        end else begin
            a = int'(slots[1]);
            b = int'(slots[2]);
            c = int'(slots[4]);
            base = BASE_ADD + c;
            v[0] = base + (b - MID_PULSE) - TRIM_OFS;
            v[1] = base + (a - MID_PULSE) - TRIM_OFS;
            v[2] = base - (b - MID_PULSE) + TRIM_OFS;
            v[3] = base - (a - MID_PULSE) + TRIM_OFS;
            v[4] = base;
            for (k = 0; k < 5; k++) begin
                r.servo_index = 3'(k);
                r.angle_x20 = clamp_angle(v[k]);
                r.last = (3'(k) == SERVO_LAST);
                angles_due.push_back(r);
            end
        end
    endtask

    function automatic t_in mk(input logic c, input int w);
        t_in r;
        r.cmd = c;
        r.pulse_width = 16'(w);
        return r;
    endfunction

    // Driver: one transaction per accepted item, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) decode_item(i_data);
            if (!i_valid || o_ready) begin
                if (pulses_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_valid <= 1'b1;
                    i_data <= pulses_pending.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) hold_left <= HOLD_LEN;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // Monitor: compare each result against the oldest expected angle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (angles_due.size() == 0) begin
                    $error("unexpected result: servo_index %0d angle_x20 %0d last %0d",
                           o_data.servo_index, o_data.angle_x20, o_data.last);
                    n_fail++;
                end else begin
                    want = angles_due.pop_front();
                    if (o_data.servo_index !== want.servo_index) begin
                        $error("servo_index expected %0d actual %0d",
                               want.servo_index, o_data.servo_index);
                        n_fail++;
                    end
                    if (o_data.angle_x20 !== want.angle_x20) begin
                        $error("angle_x20 expected %0d actual %0d",
                               want.angle_x20, o_data.angle_x20);
                        n_fail++;
                    end
                    if (o_data.last !== want.last) begin
                        $error("last expected %0d actual %0d", want.last, o_data.last);
                        n_fail++;
                    end
                end
            end
            i_ready <= (hold_left == 0) && !hold_start &&
                       ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == LIMIT) begin
            $display("FAIL ppm_capture_servo_mixer");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= 16'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_THR:  thr_q = 16'(val);
            CFG_MIN_ANGLE: min_q = 12'(val);
            CFG_MAX_ANGLE: max_q = 12'(val);
            default: ;
        endcase
    endtask

    // Sync gap followed by n_ch channel widths that stay at or under the threshold
    task automatic add_frame(input int thr, input int n_ch, input bit wide);
        int k;
        int w;
        if (thr < 65535) pulses_pending.push_back(mk(CMD_CAPTURE, $urandom_range(thr + 1, 65535)));
        else pulses_pending.push_back(mk(CMD_CAPTURE, $urandom_range(0, 65535)));
        for (k = 0; k < n_ch; k++) begin
            if (wide && $urandom_range(0, 1) == 1) w = $urandom_range(0, thr);
            else w = $urandom_range(800, 2200);
            if (w > thr) w = thr;
            pulses_pending.push_back(mk(CMD_CAPTURE, w));
        end
    endtask

    task automatic add_mix();
        pulses_pending.push_back(mk(CMD_MIX, $urandom_range(0, 65535)));
    endtask

    task automatic gen_pulses(input int n, input int thr, input bit wide);
        int cnt;
        int r;
        int k;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                add_frame(thr, SLOTS - 1, wide);
                add_mix();
                cnt += SLOTS + 1;
            end else if (r < 75) begin
                // broken frame, mixed part way through or left unfinished
                k = $urandom_range(0, SLOTS - 2);
                add_frame(thr, k, wide);
                if ($urandom_range(0, 1) == 1) add_mix();
                cnt += k + 2;
            end else if (r < 88) begin
                add_mix();
                cnt++;
            end else begin
                pulses_pending.push_back(mk(CMD_CAPTURE, $urandom_range(0, 65535)));
                cnt++;
            end
        end
    endtask

    task automatic drain();
        while (pulses_pending.size() != 0 || i_valid || angles_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input int thr, input int lo, input int hi, input int s_idle,
                             input int r_stall, input int n, input bit long_hold);
        cfg_write(CFG_SYNC_THR, thr);
        cfg_write(CFG_MIN_ANGLE, lo);
        cfg_write(CFG_MAX_ANGLE, hi);
        @(negedge i_clk);
        send_idle = s_idle;
        recv_stall = r_stall;
        gen_pulses(n, thr, thr > 60000 || $urandom_range(0, 3) == 0);
        if (long_hold) begin
            @(posedge i_clk);
            hold_start <= 1'b1;
            @(posedge i_clk);
            hold_start <= 1'b0;
        end
        drain();
    endtask

    initial begin
        thr_q = SYNC_THR_RST;
        min_q = MIN_ANGLE_RST;
        max_q = MAX_ANGLE_RST;
        foreach (slots[k]) slots[k] = '0;
        slot_cnt = 4'd1;
        in_frame = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty slots, ignored captures, partial and full frames
        pulses_pending.push_back(mk(CMD_MIX, 65535));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1500));
        pulses_pending.push_back(mk(CMD_CAPTURE, 2050));
        pulses_pending.push_back(mk(CMD_CAPTURE, 65535));
        pulses_pending.push_back(mk(CMD_CAPTURE, 0));
        pulses_pending.push_back(mk(CMD_CAPTURE, 2050));
        pulses_pending.push_back(mk(CMD_MIX, 0));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1000));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1200));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1500));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1800));
        pulses_pending.push_back(mk(CMD_CAPTURE, 2000));
        pulses_pending.push_back(mk(CMD_CAPTURE, 2050));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1700));
        pulses_pending.push_back(mk(CMD_MIX, 21845));
        pulses_pending.push_back(mk(CMD_CAPTURE, 2051));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1000));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1000));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1000));
        pulses_pending.push_back(mk(CMD_CAPTURE, 1000));
        pulses_pending.push_back(mk(CMD_MIX, 43690));
        drain();

        run_phase(65534, 0, 3600, 0, 0, 110, 1'b0);
        run_phase(0, 0, 0, 47, 0, 30, 1'b0);
        run_phase(65535, 1300, 2300, 0, 47, 30, 1'b0);
        run_phase($urandom_range(1800, 3000), $urandom_range(0, 3600),
                  $urandom_range(0, 3600), 16, 16, 100, 1'b0);
        // inverted clamp window
        run_phase(2050, 3600, 0, 47, 0, 50, 1'b0);
        // hold the output off so the block backs up into its input
        run_phase(2100, 1000, 2600, 0, 0, 110, 1'b1);

        repeat (SETTLE) @(posedge i_clk);
        if (n_fail == 0 && angles_due.size() == 0) begin
            $display("PASS ppm_capture_servo_mixer");
        end else begin
            $display("FAIL ppm_capture_servo_mixer");
        end
        $finish;
    end

endmodule
